>>> rtl/pcq_pkg.sv
// Package for the priority command queue: entry layout, operation and status codes, shared types.
`default_nettype none

package pcq_pkg;

    // Default table depth
    localparam int PCQ_DEPTH = 64;

    // Packed widths of the stream channels
    localparam int PCQ_IN_DATA_W  = 64;
    localparam int PCQ_IN_USER_W  = 8;
    localparam int PCQ_OUT_DATA_W = 88;
    localparam int PCQ_CNT_OUT_W  = 7;

    // Operation codes
    typedef enum logic [3:0] {
        OP_ADD            = 4'd0,
        OP_ADD_UNLESS_KEY = 4'd1,
        OP_ADD_UNLESS_TYP = 4'd2,
        OP_SEARCH_KEY     = 4'd3,
        OP_SEARCH_TYPE    = 4'd4,
        OP_COUNT_POINT    = 4'd5,
        OP_POP_MAX        = 4'd6,
        OP_POP_MAX_POINT  = 4'd7,
        OP_CLEAR          = 4'd8
    } op_t;

    // Status codes
    localparam logic [1:0] STS_DONE = 2'd0;
    localparam logic [1:0] STS_DUP  = 2'd1;
    localparam logic [1:0] STS_NONE = 2'd2;
    localparam logic [1:0] STS_FULL = 2'd3;

    // One stored command, type in the lowest bits
    typedef struct packed {
        logic [31:0] payload;
        logic [15:0] point_id;
        logic [7:0]  priority_val;
        logic [7:0]  cmd_type;
    } entry_t;

    // Compare results for one entry against the request
    typedef struct packed {
        logic key_hit;
        logic type_hit;
        logic point_hit;
        logic prio_gt;
    } match_t;

    // Result fields gathered before the output register
    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [6:0] match_count;
        entry_t     ent;
    } res_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_EVAL   = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

endpackage

`default_nettype wire

>>> rtl/pcq_mem.sv
// Entry table storage: one write port and one registered read port.
`default_nettype none

module pcq_mem
    import pcq_pkg::*;
#(
    parameter int DEPTH = PCQ_DEPTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic [AW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Write one entry and read one entry each cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/pcq_match.sv
// Shared compare unit: checks one entry read from the table against the request key.
`default_nettype none

module pcq_match
    import pcq_pkg::*;
(
    input  wire entry_t      ent,
    input  wire logic [7:0]  req_type,
    input  wire logic [7:0]  req_prio,
    input  wire logic [15:0] req_point,
    input  wire logic [7:0]  best_prio,
    output match_t           result
);

    logic type_eq;
    logic point_eq;

    // Field compares
    assign type_eq  = (ent.cmd_type == req_type);
    assign point_eq = (ent.point_id == req_point);

    // Full key needs a real point on the request
    assign result.key_hit   = type_eq && (ent.priority_val == req_prio) &&
                              (req_point != 16'd0) && point_eq;
    assign result.type_hit  = type_eq;
    assign result.point_hit = point_eq;
    assign result.prio_gt   = (ent.priority_val > best_prio);

endmodule

`default_nettype wire

>>> rtl/priority_command_queue.sv
// Top level of the priority command queue: stream ports, sequencer and result register.
//
// Usage: one command enters on the s_axis channel (operation in tuser, key fields and
// payload in tdata) and exactly one result leaves on the m_axis channel. s_axis_tready
// is high only while the sequencer is idle; one command is worked on at a time.
// Add, clear and unused codes go straight to evaluation and then to the result; searches,
// count and conditional adds first scan every stored entry; pops scan as well and then
// move each entry behind the popped one down one place. The pace is set by the single
// read port of the entry table: the scan reads one entry per cycle through the shared
// compare unit, and the gap left by a pop is closed one entry per cycle.
// The result sits in an output register; a new command is taken while it waits, and
// a finished result holds in the sequencer until the register is free, so a stalled
// receiver only stops the queue after one further command. Reset empties the table
// at once (the count goes to zero, no clearing pass) and drops any pending result.
// Parameter QUEUE_DEPTH sets the table size; match_count and occupancy are reported
// in 7 bits.
`default_nettype none

module priority_command_queue
    import pcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = PCQ_DEPTH
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // cmd_type[7:0], priority_req[15:8], point_id[31:16], payload[63:32]
    input  wire logic [PCQ_IN_DATA_W-1:0]  s_axis_tdata,
    // operation[3:0], zero fill [7:4]
    input  wire logic [PCQ_IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // status[1:0], found[2], match_count[9:3], out_cmd_type[17:10],
    // out_priority[25:18], out_point_id[41:26], out_payload[73:42],
    // occupancy[80:74], zero fill [87:81]
    output logic [PCQ_OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    state_t         state_reg, state_next;
    op_t            op_reg, op_next;
    entry_t         req_reg, req_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  ptr_reg, ptr_next;
    logic           pend_reg, pend_next;
    logic [AW-1:0]  pend_idx_reg, pend_idx_next;
    logic           hit_reg, hit_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [7:0]     best_reg, best_next;
    logic [AW-1:0]  idx_reg, idx_next;
    entry_t         take_reg, take_next;
    res_t           res_reg, res_next;
    logic           m_valid_reg, m_valid_next;
    logic [PCQ_OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    entry_t         mem_wdata;
    logic [AW-1:0]  mem_raddr;
    entry_t         mem_rdata;
    match_t         cmp;
    logic           in_xfer;

    pcq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pcq_match u_match (
        .ent       (mem_rdata),
        .req_type  (req_reg.cmd_type),
        .req_prio  (req_reg.priority_val),
        .req_point (req_reg.point_id),
        .best_prio (best_reg),
        .result    (cmp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Sequencer: scan, decide, close the gap, hand off the result
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        req_next      = req_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        cnt_next      = cnt_reg;
        best_next     = best_reg;
        idx_next      = idx_reg;
        take_next     = take_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[AW-1:0];
        mem_wdata     = req_reg;
        mem_raddr     = ptr_reg[AW-1:0];

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next               = op_t'(s_axis_tuser[3:0]);
                    req_next.cmd_type     = s_axis_tdata[7:0];
                    req_next.priority_val = s_axis_tdata[15:8];
                    req_next.point_id     = s_axis_tdata[31:16];
                    req_next.payload      = s_axis_tdata[63:32];
                    ptr_next              = '0;
                    hit_next              = 1'b0;
                    cnt_next              = '0;
                    best_next             = 8'd0;
                    idx_next              = '0;
                    take_next             = '0;
                    case (s_axis_tuser[3:0])
                        OP_ADD_UNLESS_KEY, OP_ADD_UNLESS_TYP, OP_SEARCH_KEY,
                        OP_SEARCH_TYPE, OP_COUNT_POINT, OP_POP_MAX,
                        OP_POP_MAX_POINT: state_next = ST_SCAN;
                        default:          state_next = ST_EVAL;
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue the next read
                if (ptr_reg < count_reg)
                begin
                    mem_raddr     = ptr_reg[AW-1:0];
                    ptr_next      = ptr_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg[AW-1:0];
                end
                // Check the entry that arrived
                if (pend_reg)
                begin
                    case (op_reg)
                        OP_ADD_UNLESS_KEY, OP_SEARCH_KEY:
                        begin
                            if (cmp.key_hit)
                            begin
                                hit_next = 1'b1;
                            end
                        end
                        OP_ADD_UNLESS_TYP, OP_SEARCH_TYPE:
                        begin
                            if (cmp.type_hit)
                            begin
                                hit_next = 1'b1;
                            end
                        end
                        OP_COUNT_POINT:
                        begin
                            if (cmp.point_hit && (req_reg.point_id != 16'd0))
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        OP_POP_MAX:
                        begin
                            if (cmp.prio_gt)
                            begin
                                best_next = mem_rdata.priority_val;
                                idx_next  = pend_idx_reg;
                                take_next = mem_rdata;
                            end
                            else if (pend_idx_reg == '0)
                            begin
                                take_next = mem_rdata;
                            end
                        end
                        OP_POP_MAX_POINT:
                        begin
                            if (cmp.point_hit && cmp.prio_gt)
                            begin
                                best_next = mem_rdata.priority_val;
                                idx_next  = pend_idx_reg;
                                take_next = mem_rdata;
                                hit_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if ((ptr_reg >= count_reg) && !pend_reg)
                begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                res_next   = '0;
                state_next = ST_RESULT;
                case (op_reg)
                    OP_ADD, OP_ADD_UNLESS_KEY, OP_ADD_UNLESS_TYP:
                    begin
                        if ((op_reg != OP_ADD) && hit_reg)
                        begin
                            res_next.status = STS_DUP;
                        end
                        else if (count_reg < DEPTH_C)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            res_next.status = STS_FULL;
                        end
                    end
                    OP_SEARCH_KEY, OP_SEARCH_TYPE:
                    begin
                        res_next.found  = hit_reg;
                        res_next.status = hit_reg ? STS_DONE : STS_NONE;
                    end
                    OP_COUNT_POINT:
                    begin
                        res_next.match_count = 7'(cnt_reg);
                    end
                    OP_POP_MAX, OP_POP_MAX_POINT:
                    begin
                        if (((op_reg == OP_POP_MAX) && (count_reg != '0)) ||
                            ((op_reg == OP_POP_MAX_POINT) && hit_reg))
                        begin
                            res_next.ent = take_reg;
                            ptr_next     = CW'(idx_reg) + 1'b1;
                            state_next   = ST_SHIFT;
                        end
                        else
                        begin
                            res_next.status = STS_NONE;
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_SHIFT:
            begin
                // Read the entry behind the gap
                if (ptr_reg < count_reg)
                begin
                    mem_raddr = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                // Move it down one place
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = mem_rdata;
                    idx_next  = idx_reg + 1'b1;
                end
                if ((ptr_reg >= count_reg) && !pend_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                // Load the output register once it is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, 7'(count_reg), res_reg.ent.payload,
                                    res_reg.ent.point_id, res_reg.ent.priority_val,
                                    res_reg.ent.cmd_type, res_reg.match_count,
                                    res_reg.found, res_reg.status};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        req_reg      <= req_next;
        ptr_reg      <= ptr_next;
        pend_idx_reg <= pend_idx_next;
        hit_reg      <= hit_next;
        cnt_reg      <= cnt_next;
        best_reg     <= best_next;
        idx_reg      <= idx_next;
        take_reg     <= take_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

endmodule

`default_nettype wire
